FILE: rtl/dewq_pkg.sv
// Package for the double-ended word queue: request and response payload types,
// operation codes and status codes. It depends on nothing else.
`default_nettype none

package dewq_pkg;

   // Operation codes carried in the kind field of a request.
   localparam logic [2:0] KIND_BACK_PUSH  = 3'd0;
   localparam logic [2:0] KIND_FRONT_PUSH = 3'd1;
   localparam logic [2:0] KIND_BACK_POP   = 3'd2;
   localparam logic [2:0] KIND_FRONT_POP  = 3'd3;
   localparam logic [2:0] KIND_READ_AT    = 3'd4;
   localparam logic [2:0] KIND_WRITE_AT   = 3'd5;

   // Status codes returned with every response.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_POSITION  = 2'd3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  position;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_word;
      logic [31:0] front_word;
      logic [31:0] back_word;
      logic [4:0]  occupancy;
      logic        is_empty;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/double_ended_word_queue.sv
// Double-ended word queue over a ring store. Uses dewq_pkg and dewq_ram.
// A request is registered in req_ff when it is accepted, moves on into s2_ff,
// and its response is strobed from rsp_strobe_ff.
// Throughput: one request per cycle while busy is low; the single store read port sets the rate.
// Reset (synchronous) empties the queue and raises busy for one cycle after it.
`default_nettype none

module double_ended_word_queue #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire dewq_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output dewq_pkg::rsp_type     rsp_data
);

   // Only the low 32 bits of a word can ever be written, so the store keeps
   // no more than that.
   localparam int KEEP_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int SUM_BITS  = ((CNT_BITS > 4) ? CNT_BITS : 4) + 1;

   // Sources for the front and back word registers in the second stage.
   localparam logic [1:0] SEL_KEEP  = 2'd0;
   localparam logic [1:0] SEL_VALUE = 2'd1;
   localparam logic [1:0] SEL_READ  = 2'd2;
   localparam logic [1:0] SEL_CLEAR = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [1:0]  status;
      logic [1:0]  front_sel;
      logic [1:0]  back_sel;
      logic        read_sel;
      logic [31:0] value;
   } stage_type;

   // Sums of a slot and an offset stay below twice the depth, so one
   // conditional subtract brings them back into the ring.
   function automatic logic [IDX_BITS-1:0] wrap(input logic [SUM_BITS-1:0] s);
      if (s >= SUM_BITS'(DEPTH)) begin
         return IDX_BITS'(s - SUM_BITS'(DEPTH));
      end
      return IDX_BITS'(s);
   endfunction

   // Handshake and first stage: the request is registered as it is accepted.
   logic              busy_ff;
   logic              s1_valid_ff;
   dewq_pkg::req_type req_ff;
   logic              accept;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= 1'b0;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Queue state: slot of the front word and number of words held.
   logic [IDX_BITS-1:0] head_ff, head_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   logic [SUM_BITS-1:0] head_ext, cnt_ext, pos_ext;
   logic                is_full, is_empty_now, pos_ok, pos_last;
   logic [IDX_BITS-1:0] head_dec;
   logic [31:0]         value_masked;

   logic                wr_en, rd_en;
   logic [IDX_BITS-1:0] wr_addr, rd_addr;
   logic [KEEP_BITS-1:0] rd_data;
   stage_type           s2_ff, s2_in;

   assign head_ext     = SUM_BITS'(head_ff);
   assign cnt_ext      = SUM_BITS'(count_ff);
   assign pos_ext      = SUM_BITS'(req_ff.position);
   assign is_full      = (count_ff == CNT_BITS'(DEPTH));
   assign is_empty_now = (count_ff == '0);
   assign pos_ok       = (pos_ext < cnt_ext);
   assign pos_last     = (pos_ext == cnt_ext - SUM_BITS'(1));
   assign head_dec     = (head_ff == '0) ? IDX_BITS'(DEPTH - 1) : head_ff - IDX_BITS'(1);
   assign value_masked = 32'(req_ff.value[KEEP_BITS-1:0]);

   // First stage decode. Every request touches at most one slot for writing
   // and one for reading, and the new front or back word comes either from the
   // request itself or from that single read, or it is cleared or kept.
   always_comb begin
      head_in         = head_ff;
      count_in        = count_ff;
      wr_en           = 1'b0;
      wr_addr         = wrap(head_ext + pos_ext);
      rd_en           = 1'b0;
      rd_addr         = wrap(head_ext + pos_ext);
      s2_in.valid     = s1_valid_ff;
      s2_in.status    = dewq_pkg::STATUS_OK;
      s2_in.front_sel = SEL_KEEP;
      s2_in.back_sel  = SEL_KEEP;
      s2_in.read_sel  = 1'b0;
      s2_in.value     = value_masked;

      case (req_ff.kind)
         dewq_pkg::KIND_BACK_PUSH: begin
            if (is_full) begin
               s2_in.status = dewq_pkg::STATUS_FULL;
            end else begin
               wr_en           = s1_valid_ff;
               wr_addr         = wrap(head_ext + cnt_ext);
               count_in        = count_ff + CNT_BITS'(1);
               s2_in.back_sel  = SEL_VALUE;
               s2_in.front_sel = is_empty_now ? SEL_VALUE : SEL_KEEP;
            end
         end
         dewq_pkg::KIND_FRONT_PUSH: begin
            if (is_full) begin
               s2_in.status = dewq_pkg::STATUS_FULL;
            end else begin
               wr_en           = s1_valid_ff;
               wr_addr         = head_dec;
               head_in         = head_dec;
               count_in        = count_ff + CNT_BITS'(1);
               s2_in.front_sel = SEL_VALUE;
               s2_in.back_sel  = is_empty_now ? SEL_VALUE : SEL_KEEP;
            end
         end
         dewq_pkg::KIND_BACK_POP: begin
            if (is_empty_now) begin
               s2_in.status = dewq_pkg::STATUS_EMPTY;
            end else begin
               count_in = count_ff - CNT_BITS'(1);
               if (count_ff == CNT_BITS'(1)) begin
                  s2_in.front_sel = SEL_CLEAR;
                  s2_in.back_sel  = SEL_CLEAR;
               end else begin
                  // The word just in front of the old back becomes the back.
                  rd_en          = s1_valid_ff;
                  rd_addr        = wrap(head_ext + cnt_ext - SUM_BITS'(2));
                  s2_in.back_sel = SEL_READ;
               end
            end
         end
         dewq_pkg::KIND_FRONT_POP: begin
            if (is_empty_now) begin
               s2_in.status = dewq_pkg::STATUS_EMPTY;
            end else begin
               head_in  = wrap(head_ext + SUM_BITS'(1));
               count_in = count_ff - CNT_BITS'(1);
               if (count_ff == CNT_BITS'(1)) begin
                  s2_in.front_sel = SEL_CLEAR;
                  s2_in.back_sel  = SEL_CLEAR;
               end else begin
                  rd_en           = s1_valid_ff;
                  rd_addr         = wrap(head_ext + SUM_BITS'(1));
                  s2_in.front_sel = SEL_READ;
               end
            end
         end
         dewq_pkg::KIND_READ_AT: begin
            if (!pos_ok) begin
               s2_in.status = dewq_pkg::STATUS_POSITION;
            end else begin
               rd_en          = s1_valid_ff;
               s2_in.read_sel = 1'b1;
            end
         end
         dewq_pkg::KIND_WRITE_AT: begin
            if (!pos_ok) begin
               s2_in.status = dewq_pkg::STATUS_POSITION;
            end else begin
               // Overwriting an end word must refresh the held copy of it.
               wr_en           = s1_valid_ff;
               s2_in.front_sel = (pos_ext == '0) ? SEL_VALUE : SEL_KEEP;
               s2_in.back_sel  = pos_last ? SEL_VALUE : SEL_KEEP;
            end
         end
         default: begin
            // Unknown kinds do nothing and report ok.
         end
      endcase

      if (!s1_valid_ff) begin
         head_in  = head_ff;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         count_ff    <= '0;
         s2_ff.valid <= 1'b0;
      end else begin
         head_ff     <= head_in;
         count_ff    <= count_in;
         s2_ff.valid <= s2_in.valid;
      end
      s2_ff.status    <= s2_in.status;
      s2_ff.front_sel <= s2_in.front_sel;
      s2_ff.back_sel  <= s2_in.back_sel;
      s2_ff.read_sel  <= s2_in.read_sel;
      s2_ff.value     <= s2_in.value;
   end

   dewq_ram #(
      .DEPTH (DEPTH),
      .WIDTH (KEEP_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ff.value[KEEP_BITS-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Second stage: the front and back word registers take their new values
   // and the response is formed. While a request sits here, count_ff already
   // holds the count after that request.
   logic [31:0]       front_word_ff, front_word_in;
   logic [31:0]       back_word_ff, back_word_in;
   logic [31:0]       read_ext;
   logic              rsp_strobe_ff;
   dewq_pkg::rsp_type rsp_ff, rsp_in;

   assign read_ext = 32'(rd_data);

   always_comb begin
      front_word_in = front_word_ff;
      back_word_in  = back_word_ff;
      if (s2_ff.valid) begin
         case (s2_ff.front_sel)
            SEL_VALUE: front_word_in = s2_ff.value;
            SEL_READ:  front_word_in = read_ext;
            SEL_CLEAR: front_word_in = '0;
            default:   front_word_in = front_word_ff;
         endcase
         case (s2_ff.back_sel)
            SEL_VALUE: back_word_in = s2_ff.value;
            SEL_READ:  back_word_in = read_ext;
            SEL_CLEAR: back_word_in = '0;
            default:   back_word_in = back_word_ff;
         endcase
      end
      rsp_in.status     = s2_ff.status;
      rsp_in.read_word  = s2_ff.read_sel ? read_ext : '0;
      rsp_in.front_word = front_word_in;
      rsp_in.back_word  = back_word_in;
      rsp_in.occupancy  = 5'(count_ff);
      rsp_in.is_empty   = (count_ff == '0);
   end

   // The held end words are cleared at reset because the queue is then empty
   // and they are reported as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_word_ff <= '0;
         back_word_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         front_word_ff <= front_word_in;
         back_word_ff  <= back_word_in;
         rsp_strobe_ff <= s2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ff.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/dewq_ram.sv
// Ring store of the double-ended word queue: one write port and one read port
// with registered read data. It has no package dependency.
`default_nettype none

module dewq_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read and write of one edge never target a slot that this read needs.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/dewq_checker.sv
// Port-level checker for the double-ended word queue and its bind statement.
// Uses dewq_pkg for the payload types.
`default_nettype none

module dewq_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_strobe,
   input wire dewq_pkg::rsp_type rsp_data
);

   logic accept;

   assign accept = start && !busy;

   // Reset flushes the pipeline, so no response follows a reset edge.
   assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("response strobed right after reset");

   // Every accepted request gets its response strobed.
   assert property (@(posedge clock) disable iff (reset) accept |-> ##3 rsp_strobe)
      else $error("accepted request lost its response");

   // No response appears without a request accepted earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 3))
      else $error("response without a request");

   // The empty flag and the occupancy agree.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.is_empty == (rsp_data.occupancy == 5'd0)))
      else $error("empty flag disagrees with occupancy");

   // An empty queue reports zero end words.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.is_empty) |->
         (rsp_data.front_word == 32'd0 && rsp_data.back_word == 32'd0))
      else $error("end words not zero on empty queue");

endmodule

bind double_ended_word_queue dewq_checker u_dewq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
